### rtl/etrb_pkg.sv
// Shared types, codes and helpers for the escaping trace ring buffer.
`default_nettype none
package etrb_pkg;

  // operation codes
  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_DRAIN   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_SENT = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_EN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_EN = 1'd1;

  // character constants
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_ALPHA_LO = 8'h37; // 'A' - 10

  typedef logic [7:0] byte_t;

  function automatic byte_t hex_digit(input logic [3:0] v);
    byte_t r;
    if (v < 4'd10) r = CH_ZERO + {4'd0, v};
    else r = CH_ALPHA_LO + {4'd0, v};
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/escaping_trace_ring_buffer.sv
// Escaping circular trace buffer, overwrite oldest when full.
// A byte read or sink transfer passes the store read register and S_RD before its result
// is registered; every other result (acknowledge, end mark) shows the cycle after start.
// Busy holds off new items while a byte read or drain is in S_RD or a stored write is in
// S_WR (one store write per cycle, three for an escaped byte); other items need no wait.
// Reset: synchronous active-low rst_n zeroes pointers, log on, drain off; store kept.
`default_nettype none
module escaping_trace_ring_buffer
  import etrb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16384
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [2:0]           in_operation,
  input  wire logic [7:0]           in_data_byte,
  input  wire logic                 in_sink_ready,
  output logic                      out_valid,
  output logic [1:0]                out_result_kind,
  output logic [7:0]                out_result_byte,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(STORE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WR   = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] old_ptr_r, old_ptr_nxt;
  logic [AW-1:0] drn_ptr_r, drn_ptr_nxt;
  logic [AW-1:0] rdr_ptr_r, rdr_ptr_nxt;
  logic          log_en_r, log_en_nxt;
  logic          drn_en_r, drn_en_nxt;
  byte_t         data_r, data_nxt;
  logic          esc_r, esc_nxt;
  logic [1:0]    widx_r, widx_nxt;
  logic [1:0]    rd_kind_r, rd_kind_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  byte_t         out_byte_r, out_byte_nxt;

  byte_t         mem [STORE_DEPTH];
  byte_t         rd_data_r;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  byte_t         wr_byte;
  logic          accept;
  logic          is_ctrl;
  logic [AW-1:0] wr_ptr_inc;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_result_byte = out_byte_r;

  assign is_ctrl = (in_data_byte < CTRL_LIMIT) && (in_data_byte != CH_CR)
                   && (in_data_byte != CH_LF);

  assign mem_we     = (state_r == S_WR);
  assign mem_addr   = mem_we ? wr_ptr_r
                      : ((in_operation == OP_READ) ? rdr_ptr_r : drn_ptr_r);
  assign wr_ptr_inc = next_pos(wr_ptr_r);

  always_comb begin
    case (widx_r)
      2'd0:    wr_byte = esc_r ? CH_CARET : data_r;
      2'd1:    wr_byte = hex_digit(data_r[7:4]);
      default: wr_byte = hex_digit(data_r[3:0]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wr_byte;
    end
    rd_data_r <= mem[mem_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    old_ptr_nxt   = old_ptr_r;
    drn_ptr_nxt   = drn_ptr_r;
    rdr_ptr_nxt   = rdr_ptr_r;
    log_en_nxt    = log_en_r;
    drn_en_nxt    = drn_en_r;
    data_nxt      = data_r;
    esc_nxt       = esc_r;
    widx_nxt      = widx_r;
    rd_kind_nxt   = rd_kind_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = KIND_ACK;
    out_byte_nxt  = '0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOG_EN:   log_en_nxt = cfg_data;
        CFG_DRAIN_EN: drn_en_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_operation)
            OP_WRITE: begin
              if (log_en_r) begin
                data_nxt  = in_data_byte;
                esc_nxt   = is_ctrl;
                widx_nxt  = 2'd0;
                state_nxt = S_WR;
              end
            end
            OP_RESTART: rdr_ptr_nxt = old_ptr_r;
            OP_READ: begin
              if (rdr_ptr_r == wr_ptr_r) begin
                out_kind_nxt = KIND_END;
              end else begin
                out_valid_nxt = 1'b0;
                rd_kind_nxt   = KIND_BYTE;
                rdr_ptr_nxt   = next_pos(rdr_ptr_r);
                state_nxt     = S_RD;
              end
            end
            OP_DRAIN: begin
              if (drn_en_r && (drn_ptr_r != wr_ptr_r) && in_sink_ready) begin
                out_valid_nxt = 1'b0;
                rd_kind_nxt   = KIND_SENT;
                drn_ptr_nxt   = next_pos(drn_ptr_r);
                state_nxt     = S_RD;
              end
            end
            OP_CLEAR: begin
              wr_ptr_nxt  = '0;
              old_ptr_nxt = '0;
              drn_ptr_nxt = '0;
              rdr_ptr_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_WR: begin
        // store one byte; push the oldest entry out when the ring would close
        if (wr_ptr_inc == old_ptr_r) begin
          old_ptr_nxt = next_pos(old_ptr_r);
        end
        wr_ptr_nxt = wr_ptr_inc;
        widx_nxt   = widx_r + 2'd1;
        if (!esc_r || (widx_r == 2'd2)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = rd_kind_r;
        out_byte_nxt  = rd_data_r;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      old_ptr_r   <= '0;
      drn_ptr_r   <= '0;
      rdr_ptr_r   <= '0;
      log_en_r    <= 1'b1;
      drn_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      old_ptr_r   <= old_ptr_nxt;
      drn_ptr_r   <= drn_ptr_nxt;
      rdr_ptr_r   <= rdr_ptr_nxt;
      log_en_r    <= log_en_nxt;
      drn_en_r    <= drn_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    esc_r      <= esc_nxt;
    widx_r     <= widx_nxt;
    rd_kind_r  <= rd_kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
  end

endmodule
`default_nettype wire

### rtl/etrb_chk.sv
// Port-level checker for the escaping trace ring buffer, with its bind.
`default_nettype none
module etrb_chk
  import etrb_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic [2:0]           in_operation,
  input wire logic                 out_valid,
  input wire logic [1:0]           out_result_kind,
  input wire logic [7:0]           out_result_byte
);

  // after reset nothing is in flight
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result right after reset");

  // restart and clear answer with an acknowledge in the next cycle
  a_restart_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_RESTART || in_operation == OP_CLEAR))
    |=> (out_valid && out_result_kind == KIND_ACK && !busy))
    else $error("restart/clear did not acknowledge");

  // acknowledge and end mark carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == KIND_ACK || out_result_kind == KIND_END))
    |-> (out_result_byte == 8'd0))
    else $error("nonzero byte on ack or end mark");

  // a read never yields a sink transfer (a drain likewise never yields a read byte; only the read side is checked here)
  a_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_READ)
    |=> ##1 (!out_valid || out_result_kind != KIND_SENT))
    else $error("read produced a sink result");

endmodule

bind escaping_trace_ring_buffer etrb_chk u_etrb_chk (.*);
`default_nettype wire

### tb/sv/etrb_checker.sv
// Checker for the escaping trace ring buffer: predicts each result and compares it.
`timescale 1ns / 100ps
module etrb_checker
  import etrb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 16384
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [2:0]           in_operation,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_sink_ready,
  input  logic                 out_valid,
  input  logic [1:0]           out_result_kind,
  input  logic [7:0]           out_result_byte,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int unsigned PW = $clog2(STORE_DEPTH);
  localparam byte_t ASCII_A = "A";

  typedef logic [PW-1:0] slot_t;

  typedef struct packed {
    logic [1:0] kind;
    byte_t      data;
  } trace_result_t;

  trace_result_t expected_q[$];

  byte_t trace_mem [STORE_DEPTH];
  slot_t wr_slot, oldest_slot, drain_slot, rd_slot;
  logic  log_on, drain_on;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic slot_t step_slot(input slot_t s);
    if (s == slot_t'(STORE_DEPTH - 1)) return '0;
    return s + slot_t'(1);
  endfunction

  function automatic byte_t ascii_hex(input logic [3:0] nib);
    if (nib < 4'd10) return CH_ZERO + byte_t'(nib);
    return ASCII_A + byte_t'(nib) - byte_t'(10);
  endfunction

  // full store: the oldest entry gives way before the write slot reaches it
  task automatic append_byte(input byte_t b);
    slot_t nxt;
    nxt = step_slot(wr_slot);
    if (nxt == oldest_slot) oldest_slot = step_slot(oldest_slot);
    trace_mem[wr_slot] = b;
    wr_slot = nxt;
  endtask

  task automatic predict_trace(input logic [2:0] op, input byte_t b, input logic rdy);
    trace_result_t r;
    r.kind = KIND_ACK;
    r.data = '0;
    case (op)
      OP_WRITE: begin
        if (log_on) begin
          if (b < CTRL_LIMIT && b != CH_CR && b != CH_LF) begin
            append_byte(CH_CARET);
            append_byte(ascii_hex(b[7:4]));
            append_byte(ascii_hex(b[3:0]));
          end else begin
            append_byte(b);
          end
        end
      end
      OP_RESTART: rd_slot = oldest_slot;
      OP_READ: begin
        if (rd_slot == wr_slot) begin
          r.kind = KIND_END;
        end else begin
          r.kind = KIND_BYTE;
          r.data = trace_mem[rd_slot];
          rd_slot = step_slot(rd_slot);
        end
      end
      OP_DRAIN: begin
        if (drain_on && drain_slot != wr_slot && rdy) begin
          r.kind = KIND_SENT;
          r.data = trace_mem[drain_slot];
          drain_slot = step_slot(drain_slot);
        end
      end
      OP_CLEAR: begin
        wr_slot = '0;
        oldest_slot = '0;
        drain_slot = '0;
        rd_slot = '0;
      end
      default: ;
    endcase
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    trace_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      wr_slot = '0;
      oldest_slot = '0;
      drain_slot = '0;
      rd_slot = '0;
      log_on = 1'b1;
      drain_on = 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result kind %0d byte %02h", $time,
                     out_result_kind, out_result_byte);
        end else begin
          want = expected_q.pop_front();
          if (out_result_kind !== want.kind || out_result_byte !== want.data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected kind %0d byte %02h, got kind %0d byte %02h",
                       $time, want.kind, want.data, out_result_kind, out_result_byte);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LOG_EN:   log_on = cfg_data;
          CFG_DRAIN_EN: drain_on = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) predict_trace(in_operation, in_data_byte, in_sink_ready);
    end
    pending = expected_q.size();
  end

endmodule

### tb/sv/tb_escaping_trace_ring_buffer.sv
// Top testbench for the escaping trace ring buffer: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_escaping_trace_ring_buffer;
  import etrb_pkg::*;

  localparam int unsigned STORE_DEPTH = 16384;
  localparam logic [2:0] OP_LAST = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [2:0]           in_operation;
  logic [7:0]           in_data_byte;
  logic                 in_sink_ready;
  logic                 out_valid;
  logic [1:0]           out_result_kind;
  logic [7:0]           out_result_byte;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic                 cfg_data;
  int                   fail_count;
  int                   pending;
  logic                 no_gaps;

  escaping_trace_ring_buffer #(.STORE_DEPTH(STORE_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_data_byte(in_data_byte),
    .in_sink_ready(in_sink_ready), .out_valid(out_valid),
    .out_result_kind(out_result_kind), .out_result_byte(out_result_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  etrb_checker #(.STORE_DEPTH(STORE_DEPTH)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_data_byte(in_data_byte),
    .in_sink_ready(in_sink_ready), .out_valid(out_valid),
    .out_result_kind(out_result_kind), .out_result_byte(out_result_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // hold start until the block takes the item
  task automatic send_item(input logic [2:0] op, input byte_t b, input logic rdy);
    @(negedge clk);
    start <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    in_sink_ready <= rdy;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return;
    n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk);
    start <= 1'b0;
    in_data_byte <= byte_t'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic byte_t pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return byte_t'($urandom_range(0, 31));
    if (r < 40) return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
    if (r < 75) return byte_t'($urandom_range(32, 126));
    return byte_t'($urandom_range(127, 255));
  endfunction

  task automatic random_item();
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_WRITE;
    else if (r < 50) op = OP_RESTART;
    else if (r < 75) op = OP_READ;
    else if (r < 91) op = OP_DRAIN;
    else if (r < 95) op = OP_CLEAR;
    else op = 3'($urandom_range(OP_CLEAR + 1, OP_LAST));
    send_item(op, pick_char(), $urandom_range(0, 3) != 0);
    if ($urandom_range(0, 49) == 0) no_gaps = ~no_gaps;
    idle_gap();
  endtask

  task automatic run_phase(input logic log_en, input logic drain_en, input int count);
    wait_drained();
    set_reg(CFG_LOG_EN, log_en);
    set_reg(CFG_DRAIN_EN, drain_en);
    repeat (count) random_item();
  endtask

  initial begin
    byte_t ctl;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_WRITE;
    in_data_byte = '0;
    in_sink_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LOG_EN;
    cfg_data = 1'b0;
    no_gaps = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, escapes and their exceptions, each operation
    set_reg(CFG_DRAIN_EN, 1'b1);
    send_item(OP_CLEAR, 8'h00, 1'b1);
    send_item(OP_READ, 8'h00, 1'b1);
    send_item(OP_DRAIN, 8'h00, 1'b1);
    send_item(OP_WRITE, 8'h00, 1'b0);
    send_item(OP_WRITE, 8'h1F, 1'b0);
    send_item(OP_WRITE, CH_CR, 1'b0);
    send_item(OP_WRITE, CH_LF, 1'b0);
    send_item(OP_WRITE, 8'h7F, 1'b0);
    send_item(OP_WRITE, 8'hFF, 1'b0);
    send_item(OP_WRITE, CTRL_LIMIT, 1'b0);
    send_item(OP_DRAIN, 8'h00, 1'b0);
    send_item(OP_DRAIN, 8'h00, 1'b1);
    send_item(OP_DRAIN, 8'h00, 1'b1);
    send_item(OP_RESTART, 8'h00, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_CLEAR + 3'd1, 8'hA5, 1'b1);
    send_item(OP_LAST, 8'h5A, 1'b1);
    send_item(OP_CLEAR, 8'h00, 1'b0);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_DRAIN, 8'h00, 1'b1);

    run_phase(1'b1, 1'b1, 150);
    run_phase(1'b0, 1'b1, 80);
    run_phase(1'b1, 1'b0, 120);
    run_phase(1'b0, 1'b0, 60);
    run_phase(1'b1, 1'b1, 150);

    // burst of escaped writes while reader and drain fall behind
    wait_drained();
    send_item(OP_CLEAR, 8'h00, 1'b1);
    repeat (5) send_item(OP_WRITE, pick_char(), 1'b1);
    send_item(OP_DRAIN, 8'h00, 1'b1);
    send_item(OP_DRAIN, 8'h00, 1'b1);
    send_item(OP_RESTART, 8'h00, 1'b1);
    send_item(OP_READ, 8'h00, 1'b1);
    repeat (40) begin
      ctl = byte_t'($urandom_range(0, 31));
      if (ctl == CH_CR || ctl == CH_LF) ctl = 8'h00;
      send_item(OP_WRITE, ctl, 1'b1);
    end
    repeat (20) send_item(OP_READ, 8'h00, 1'b1);
    repeat (20) send_item(OP_DRAIN, 8'h00, 1'b1);
    send_item(OP_RESTART, 8'h00, 1'b1);
    repeat (30) send_item(OP_READ, 8'h00, 1'b1);
    no_gaps = 1'b0;
    repeat (60) random_item();

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### escaping_trace_ring_buffer.f
rtl/etrb_pkg.sv
rtl/escaping_trace_ring_buffer.sv
rtl/etrb_chk.sv
tb/sv/etrb_checker.sv
tb/sv/tb_escaping_trace_ring_buffer.sv
